### design/crcgc_pkg.sv
// Package for the CRC generate/check block: word types, register indexes,
// reset constants and the byte-wide mod-2 division function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crcgc_pkg;

	localparam int GEN_W   = 33;
	localparam int REM_W   = 32;
	localparam int BYTE_W  = 8;
	localparam int CFG_W   = GEN_W;
	localparam int CFG_IDX_W = 1;

	localparam logic [GEN_W-1:0]  RST_GENERATOR = 33'h1_04C1_1DB7;
	localparam logic [BYTE_W-1:0] RST_LEAD_BYTE = 8'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GENERATOR = 1'b0,
		REG_LEAD_BYTE = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic              mode;
		logic [BYTE_W-1:0] data_byte;
		logic              last;
		logic [REM_W-1:0]  received_check;
	} in_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_out;
		logic              last_out;
		logic [REM_W-1:0]  check_value;
		logic              check_ok;
	} out_word_t;

	// derived view of the configuration used by the datapath
	typedef struct packed {
		logic [REM_W-1:0] mask;     // ones below the generator degree
		logic [REM_W-1:0] low;      // generator without its top bit
		logic [REM_W-1:0] lead_rem; // remainder after the lead byte from zero
	} cfg_t;

	// mask[i] is set when some generator bit above i is set
	function automatic logic [REM_W-1:0] crc_mask(input logic [GEN_W-1:0] gen);
		logic [REM_W-1:0] m;
		logic             acc;
		acc = 1'b0;
		m   = '0;
		for (int i = REM_W - 1; i >= 0; i--) begin
			acc  = acc | gen[i+1];
			m[i] = acc;
		end
		return m;
	endfunction

	// one byte of MSB-first division; degree zero gives mask 0 and thus 0
	function automatic logic [REM_W-1:0] crc_div_byte(
		input logic [REM_W-1:0]  rem_in,
		input logic [BYTE_W-1:0] byte_in,
		input logic [REM_W-1:0]  mask,
		input logic [REM_W-1:0]  low
	);
		logic [REM_W-1:0] r;
		logic [REM_W-1:0] top_sel;
		logic             top;
		top_sel = mask ^ (mask >> 1);
		r       = rem_in & mask;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			top = (|(r & top_sel)) ^ byte_in[i];
			r   = (r << 1) & mask;
			if (top) begin
				r = r ^ low;
			end
		end
		return r;
	endfunction

	localparam logic [REM_W-1:0] RST_MASK     = crc_mask(RST_GENERATOR);
	localparam logic [REM_W-1:0] RST_LOW      = RST_GENERATOR[REM_W-1:0] & RST_MASK;
	localparam logic [REM_W-1:0] RST_LEAD_REM =
		crc_div_byte('0, RST_LEAD_BYTE, RST_MASK, RST_LOW);

endpackage

`default_nettype wire

### design/crcgc_cfg.sv
// Configuration registers of the CRC block and the values derived from them.
// Depends on crcgc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crcgc_cfg import crcgc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output cfg_t                      cfg
);

	logic [GEN_W-1:0]  gen_q;
	logic [BYTE_W-1:0] lead_q;
	logic [REM_W-1:0]  lead_rem_q;

	logic [REM_W-1:0] cur_mask;
	logic [REM_W-1:0] cur_low;
	logic [REM_W-1:0] new_mask;
	logic [REM_W-1:0] new_low;
	logic [REM_W-1:0] lead_rem_gen;
	logic [REM_W-1:0] lead_rem_lead;

	always_comb begin
		cur_mask      = crc_mask(gen_q);
		cur_low       = gen_q[REM_W-1:0] & cur_mask;
		new_mask      = crc_mask(cfg_data);
		new_low       = cfg_data[REM_W-1:0] & new_mask;
		// lead remainder is refreshed with the write itself
		lead_rem_gen  = crc_div_byte('0, lead_q, new_mask, new_low);
		lead_rem_lead = crc_div_byte('0, cfg_data[BYTE_W-1:0], cur_mask, cur_low);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q      <= RST_GENERATOR;
			lead_q     <= RST_LEAD_BYTE;
			lead_rem_q <= RST_LEAD_REM;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_GENERATOR: begin
					gen_q      <= cfg_data;
					lead_rem_q <= lead_rem_gen;
				end
				REG_LEAD_BYTE: begin
					lead_q     <= cfg_data[BYTE_W-1:0];
					lead_rem_q <= lead_rem_lead;
				end
				default: begin
					lead_rem_q <= lead_rem_q;
				end
			endcase
		end
	end

	assign cfg.mask     = cur_mask;
	assign cfg.low      = cur_low;
	assign cfg.lead_rem = lead_rem_q;

endmodule

`default_nettype wire

### design/crcgc_step.sv
// Running remainder and the per-word division/compare datapath.
// Depends on crcgc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crcgc_step import crcgc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire in_word_t in_word,
	input  wire cfg_t     cfg,
	output out_word_t     result
);

	logic [REM_W-1:0] rem_q;
	logic             start_q;

	logic [REM_W-1:0] rem_in;
	logic [REM_W-1:0] rem_new;

	always_comb begin
		// at message start the lead byte is already divided in
		rem_in  = start_q ? cfg.lead_rem : rem_q;
		rem_new = crc_div_byte(rem_in, in_word.data_byte, cfg.mask, cfg.low);

		result.data_out    = in_word.data_byte;
		result.last_out    = in_word.last;
		result.check_value = in_word.last ? rem_new : '0;
		result.check_ok    = in_word.last & in_word.mode &
			(rem_new == in_word.received_check);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			start_q <= 1'b1;
		end else if (accept) begin
			if (in_word.last) begin
				rem_q   <= '0;
				start_q <= 1'b1;
			end else begin
				rem_q   <= rem_new;
				start_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### design/crcgc_outbuf.sv
// Output register with a skid slot, so input is taken while a result waits.
// Depends on crcgc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crcgc_outbuf import crcgc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire out_word_t in_word,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_word_t      out_word
);

	logic      out_valid_q;
	logic      skid_valid_q;
	out_word_t out_q;
	out_word_t skid_q;

	logic out_free;
	logic take;

	assign in_stall  = skid_valid_q;
	assign take      = in_valid & ~skid_valid_q;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | take;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : in_word;
		end else if (take) begin
			skid_q <= in_word;
		end
	end

endmodule

`default_nettype wire

### design/crc_generate_and_check.sv
// Top level of the configurable byte-stream CRC generator and checker.
// Depends on crcgc_pkg, crcgc_cfg, crcgc_step, crcgc_outbuf.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------
//   input    | in_valid / in_stall   | in_word  (in_word_t)
//   output   | out_valid / out_stall | out_word (out_word_t)
//   config   | cfg_we                | cfg_index, cfg_data
//
// One word per cycle unless the skid slot is full; results are registered.
// The byte division is an unrolled 8-step XOR network between the input
// and the output register; the lead byte remainder is precomputed on writes.
// Reset loads the default generator and lead byte and starts a new message.
// A stalled result moves into a skid slot; input stalls only when that is full.
`timescale 1ns / 1ps
`default_nettype none

module crc_generate_and_check import crcgc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_word_t             in_word,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_word_t                 out_word,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	cfg_t      cfg;
	out_word_t result;
	logic      accept;

	assign accept = in_valid & ~in_stall;

	crcgc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	crcgc_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_word (in_word),
		.cfg     (cfg),
		.result  (result)
	);

	crcgc_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (result),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire
